/* rtl/ssbf_pkg.sv */
// ----------------------------------------------------------------------------
// ssbf_pkg: shared types and constants of the sensor sample byte framer
// Holds the configuration register indexes, the reset values of the
// registers, the motion kind codes and the frame buffer type.
// ----------------------------------------------------------------------------
package ssbf_pkg;

  // Configuration register indexes.
  localparam int CFG_ADDR_W = 1;
  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;
  localparam cfg_addr_t CFG_IMU_PERIOD = 1'b0;
  localparam cfg_addr_t CFG_DEV_ID     = 1'b1;

  // Register reset values.
  localparam logic [7:0]  PERIOD_RESET = 8'd20;
  localparam logic [15:0] ID_RESET     = 16'h55AA;

  // Motion burst constants.
  localparam logic [3:0] BURST_STEPS = 4'd10;
  localparam logic [4:0] CLOSE_TAG   = 5'd31;
  localparam logic [2:0] ALL_KINDS   = 3'b111;
  localparam int         STORE_DEPTH = 9;

  // Motion event kinds.
  typedef enum logic [1:0] {
    KIND_ACCEL = 2'd0,
    KIND_GYRO  = 2'd1,
    KIND_MAG   = 2'd2,
    KIND_OTHER = 2'd3
  } imu_kind_t;

  // One item produces at most three sample bytes and four word bytes.
  localparam int FRAME_BYTES = 7;
  localparam int FRAME_CNT_W = 3;
  typedef logic [7:0] byte_t;
  typedef byte_t [FRAME_BYTES-1:0] frame_t;
  typedef logic [FRAME_CNT_W-1:0] frame_cnt_t;

endpackage

/* rtl/sensor_sample_byte_framer.sv */
// ----------------------------------------------------------------------------
// sensor_sample_byte_framer: byte framer for EMG samples and motion bursts
// Codes each sample in one to three bytes, stores motion events and, once all
// three kinds are present, sends a ten-step burst of four-byte tagged words.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  in_     | input     | in_valid / in_ready   | sample, motion event fields
//  out_    | output    | out_valid / out_ready | one framed byte, last flag
//  cfg_    | input     | cfg_valid / cfg_ready | register index, write data
//
// The frame buffer sends one byte per cycle while the output is not stalled,
// and a new item is taken in the cycle the previous frame's last byte moves
// into the output register, so the byte stream runs without gaps.
// A write of imu_period holds in_ready low while a bit-serial remainder unit
// recomputes the sample counter modulo the period.
// Reset is synchronous and active low; it clears all control state.
// A stalled output holds its beat and stops the frame buffer in place.

module sensor_sample_byte_framer #(
  parameter int COUNTER_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  // Input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [15:0]         in_emg_sample,
  input  logic                in_imu_valid,
  input  logic [1:0]          in_imu_kind,
  input  logic signed [15:0]  in_axis_x,
  input  logic signed [15:0]  in_axis_y,
  input  logic signed [15:0]  in_axis_z,
  // Output channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                out_last_byte,
  // Configuration channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  ssbf_pkg::cfg_addr_t cfg_addr,
  input  logic [15:0]         cfg_data
);
  import ssbf_pkg::*;

  localparam int BIT_W = (COUNTER_BITS > 1) ? $clog2(COUNTER_BITS) : 1;

  // Four-byte tagged word.
  function automatic logic [3:0][7:0] word_bytes(input logic [4:0] tag,
                                                  input logic [15:0] v);
    logic [3:0][7:0] b;
    b[0] = {5'b11110, tag[4:2]};
    b[1] = {2'b10, tag[1:0], v[15:12]};
    b[2] = {2'b10, v[11:6]};
    b[3] = {2'b10, v[5:0]};
    return b;
  endfunction

  // Registers
  logic [7:0]              period_r;
  logic [15:0]             dev_id_r;
  logic [COUNTER_BITS-1:0] cnt_r;
  logic [7:0]              phase_r;
  logic [15:0]             store_r [STORE_DEPTH];
  logic [2:0]              flags_r;
  logic [3:0]              burst_r;
  logic                    mod_busy_r;
  logic [BIT_W-1:0]        mod_bit_r;
  logic [7:0]              mod_rem_r;
  frame_t                  fb_r;
  frame_cnt_t              fb_left_r;
  logic                    out_valid_r;
  logic [7:0]              out_byte_r;
  logic                    out_last_r;

  // Item logic
  logic                    in_fire;
  logic                    cfg_fire;
  logic                    event_due;
  logic                    kind_store;
  logic [2:0]              flags_set;
  logic                    burst_start;
  logic [2:0]              flags_nxt;
  logic [3:0]              burst_eff;
  logic [3:0]              burst_nxt;
  logic                    word_on;
  logic [3:0]              rd_idx;
  logic [15:0]             view [STORE_DEPTH];
  logic [4:0]              word_tag;
  logic [15:0]             word_val;
  logic [3:0][7:0]         wb;
  logic [2:0][7:0]         sb;
  logic [1:0]              slen;
  frame_t                  frame_nxt;
  frame_cnt_t              frame_cnt;
  logic [COUNTER_BITS-1:0] cnt_nxt;
  logic [7:0]              phase_nxt;
  logic [8:0]              phase_inc;
  logic                    move;
  logic                    fb_done;
  logic [8:0]              mod_trial;
  logic [7:0]              mod_rem_nxt;

  assign in_fire  = in_valid && in_ready;
  assign cfg_fire = cfg_valid && cfg_ready;

  // Motion event acceptance, flags and burst start.
  always_comb begin
    event_due   = (period_r != 8'd0) && (phase_r == 8'd0) && in_imu_valid;
    kind_store  = event_due && (imu_kind_t'(in_imu_kind) != KIND_OTHER);
    flags_set   = flags_r | (kind_store ? (3'b001 << in_imu_kind) : 3'b000);
    burst_start = event_due && (flags_set == ALL_KINDS) && (burst_r == 4'd0);
    flags_nxt   = burst_start ? 3'b000 : flags_set;
    burst_eff   = burst_start ? BURST_STEPS : burst_r;
    word_on     = (burst_eff != 4'd0);
    burst_nxt   = word_on ? (burst_eff - 4'd1) : 4'd0;
    rd_idx      = burst_nxt - 4'd1;
  end

  // Store contents with this item's event written in, so a word read sees it.
  always_comb begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      view[i] = store_r[i];
    end
    for (int k = 0; k < 3; k++) begin
      if (kind_store && (in_imu_kind == 2'(k))) begin
        view[3*k]     = in_axis_x;
        view[3*k + 1] = in_axis_y;
        view[3*k + 2] = in_axis_z;
      end
    end
  end

  // Burst word selection.
  always_comb begin
    if (burst_nxt == 4'd0) begin
      word_tag = CLOSE_TAG;
      word_val = dev_id_r;
    end else begin
      word_tag = {1'b0, burst_nxt};
      word_val = view[rd_idx];
    end
    wb = word_bytes(word_tag, word_val);
  end

  // Variable-length sample code.
  always_comb begin
    sb = '0;
    if (in_emg_sample[15:7] == 9'd0) begin
      slen  = 2'd1;
      sb[0] = in_emg_sample[7:0];
    end else if (in_emg_sample[15:11] == 5'd0) begin
      slen  = 2'd2;
      sb[0] = {2'b11, in_emg_sample[11:6]};
      sb[1] = {2'b10, in_emg_sample[5:0]};
    end else begin
      slen  = 2'd3;
      sb[0] = {4'hE, in_emg_sample[15:12]};
      sb[1] = {2'b10, in_emg_sample[11:6]};
      sb[2] = {2'b10, in_emg_sample[5:0]};
    end
  end

  // Frame assembly: sample bytes first, then the burst word.
  always_comb begin
    frame_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < slen) begin
        frame_nxt[k] = sb[k];
      end
    end
    if (word_on) begin
      for (int k = 0; k < 4; k++) begin
        frame_nxt[3'(slen) + 3'(k)] = wb[k];
      end
    end
    frame_cnt = {1'b0, slen} + (word_on ? 3'd4 : 3'd0);
  end

  // Sample counter and its remainder modulo the period.
  always_comb begin
    cnt_nxt   = cnt_r + COUNTER_BITS'(1);
    phase_inc = {1'b0, phase_r} + 9'd1;
    if (&cnt_r) begin
      phase_nxt = 8'd0;
    end else if (phase_inc == {1'b0, period_r}) begin
      phase_nxt = 8'd0;
    end else begin
      phase_nxt = phase_inc[7:0];
    end
  end

  // One restoring step of the remainder unit.
  always_comb begin
    mod_trial = {mod_rem_r, cnt_r[mod_bit_r]};
    if ((period_r != 8'd0) && (mod_trial >= {1'b0, period_r})) begin
      mod_trial = mod_trial - {1'b0, period_r};
    end
    mod_rem_nxt = mod_trial[7:0];
  end

  // Handshake of the frame buffer and the output register.
  assign move      = (fb_left_r != '0) && (!out_valid_r || out_ready);
  assign fb_done   = move && (fb_left_r == frame_cnt_t'(1));
  assign in_ready  = !mod_busy_r && ((fb_left_r == '0) || fb_done);
  assign cfg_ready = !mod_busy_r;

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_last_byte = out_last_r;

  // Configuration registers and the remainder unit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r   <= PERIOD_RESET;
      dev_id_r   <= ID_RESET;
      mod_busy_r <= 1'b0;
    end else if (cfg_fire) begin
      if (cfg_addr == CFG_IMU_PERIOD) begin
        period_r   <= cfg_data[7:0];
        mod_busy_r <= 1'b1;
      end else if (cfg_addr == CFG_DEV_ID) begin
        dev_id_r <= cfg_data;
      end
    end else if (mod_busy_r && (mod_bit_r == '0)) begin
      mod_busy_r <= 1'b0;
    end
  end

  // Remainder unit datapath.
  always_ff @(posedge clk) begin
    if (cfg_fire) begin
      mod_bit_r <= BIT_W'(COUNTER_BITS - 1);
      mod_rem_r <= 8'd0;
    end else if (mod_busy_r) begin
      mod_bit_r <= mod_bit_r - BIT_W'(1);
      mod_rem_r <= mod_rem_nxt;
    end
  end

  // Item state: counter, phase, flags and burst position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      phase_r <= 8'd0;
      flags_r <= 3'b000;
      burst_r <= 4'd0;
    end else if (in_fire) begin
      cnt_r   <= cnt_nxt;
      phase_r <= phase_nxt;
      flags_r <= flags_nxt;
      burst_r <= burst_nxt;
    end else if (mod_busy_r && (mod_bit_r == '0)) begin
      phase_r <= mod_rem_nxt;
    end
  end

  // Motion store.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        store_r[i] <= '0;
      end
    end else if (in_fire) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        store_r[i] <= view[i];
      end
    end
  end

  // Frame buffer: loads a whole frame, shifts one byte out per beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_left_r <= '0;
    end else if (in_fire) begin
      fb_left_r <= frame_cnt;
    end else if (move) begin
      fb_left_r <= fb_left_r - frame_cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      fb_r <= frame_nxt;
    end else if (move) begin
      fb_r <= {8'h00, fb_r[FRAME_BYTES-1:1]};
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_byte_r <= fb_r[0];
      out_last_r <= (fb_left_r == frame_cnt_t'(1));
    end
  end

endmodule

/* rtl/ssbf_checker.sv */
// ----------------------------------------------------------------------------
// ssbf_checker: port-level checks for the sensor sample byte framer
// Watches the top level's handshakes and byte stream over time.
// ----------------------------------------------------------------------------
module ssbf_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [7:0]          out_byte,
  input logic                out_last_byte,
  input logic                cfg_valid,
  input logic                cfg_ready,
  input ssbf_pkg::cfg_addr_t cfg_addr
);
  import ssbf_pkg::*;

  // A stalled output beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last_byte))
    else $error("output beat changed while stalled");

  // Reset empties the output register.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A leading byte of a multi-byte sample or a tag byte always has bytes after it.
  a_lead_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_byte[7:6] == 2'b11) |-> !out_last_byte)
    else $error("leading byte marked as last");

  // A period write starts the remainder unit, which holds off new items.
  a_period_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready && (cfg_addr == CFG_IMU_PERIOD) |=> !in_ready && !cfg_ready)
    else $error("item or write taken during period update");

endmodule

bind sensor_sample_byte_framer ssbf_checker u_ssbf_checker (.*);
